[rtl/olpe_pkg.sv]
`default_nettype none
package olpe_pkg;

  localparam int REQ_W    = 3;
  localparam int POS_W    = 7;
  localparam int PLATE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int BEFORE_W = 6;
  localparam int AFTER_W  = 7;
  localparam int LEN_W    = 7;

  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOCATE    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the request item
    logic exec;   // check, shift cells, compare
  } cmd_t;

endpackage
`default_nettype wire

[rtl/olpe_ctrl.sv]
`default_nettype none
module olpe_ctrl (
  input  wire  logic         clk,
  input  wire  logic         rst,
  input  wire  logic         start,
  output       logic         busy,
  output       logic         done,
  output       olpe_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_EXEC: begin
          state <= S_REPORT;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        S_IDLE, S_REPORT: begin
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
          done <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.load = start && !busy;
    cmd.exec = busy;
  end

endmodule
`default_nettype wire

[rtl/olpe_dpath.sv]
`default_nettype none
module olpe_dpath #(
  parameter int LIST_DEPTH = 64
) (
  input  wire  logic                              clk,
  input  wire  logic                              rst,
  input  wire  olpe_pkg::cmd_t                    cmd,
  input  wire  logic [olpe_pkg::REQ_W-1:0]        req_type,
  input  wire  logic [olpe_pkg::POS_W-1:0]        position,
  input  wire  logic [olpe_pkg::PLATE_W-1:0]      plate,
  output       logic [olpe_pkg::STATUS_W-1:0]     status,
  output       logic [olpe_pkg::PLATE_W-1:0]      removed_plate,
  output       logic                              found,
  output       logic [olpe_pkg::BEFORE_W-1:0]     before_count,
  output       logic [olpe_pkg::AFTER_W-1:0]      after_count,
  output       logic [olpe_pkg::LEN_W-1:0]        list_length
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int PW = (CW > olpe_pkg::POS_W) ? CW : olpe_pkg::POS_W;

  logic [olpe_pkg::REQ_W-1:0]    req_q;
  logic [olpe_pkg::POS_W-1:0]    pos_q;
  logic [olpe_pkg::PLATE_W-1:0]  plate_q;

  logic [olpe_pkg::PLATE_W-1:0]  cells      [LIST_DEPTH];
  logic [olpe_pkg::PLATE_W-1:0]  cells_next [LIST_DEPTH];
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;

  logic [olpe_pkg::STATUS_W-1:0] status_q;
  logic [olpe_pkg::STATUS_W-1:0] status_next;
  logic [olpe_pkg::PLATE_W-1:0]  removed_q;
  logic [olpe_pkg::PLATE_W-1:0]  removed_next;
  logic                          locate_q;
  logic [LIST_DEPTH-1:0]         match_q;
  logic [LIST_DEPTH-1:0]         match_next;

  logic [PW-1:0]                 pos_ext;
  logic [PW-1:0]                 cnt_ext;
  logic [PW-1:0]                 ins_at;
  logic [olpe_pkg::PLATE_W-1:0]  pick;
  logic                          is_ins;
  logic                          is_del;
  logic                          is_loc;
  logic                          do_ins;
  logic                          do_del;

  logic [IW-1:0]                 last_idx;
  logic [CW-1:0]                 after_full;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req_type;
      pos_q   <= position;
      plate_q <= plate;
    end
  end

  // range, fullness and emptiness checks
  always_comb begin
    pos_ext = PW'(pos_q);
    cnt_ext = PW'(count);
    is_ins  = (req_q == olpe_pkg::REQ_INS_FRONT) || (req_q == olpe_pkg::REQ_INS_BACK) ||
              (req_q == olpe_pkg::REQ_INS_POS);
    is_del  = (req_q == olpe_pkg::REQ_DEL_POS);
    is_loc  = (req_q == olpe_pkg::REQ_LOCATE);

    case (req_q)
      olpe_pkg::REQ_INS_FRONT: ins_at = '0;
      olpe_pkg::REQ_INS_BACK:  ins_at = cnt_ext;
      default:                 ins_at = pos_ext;
    endcase

    do_ins      = 1'b0;
    do_del      = 1'b0;
    status_next = olpe_pkg::ST_OK;
    if (is_ins) begin
      if (ins_at > cnt_ext) begin
        status_next = olpe_pkg::ST_BADPOS;
      end else if (count >= CW'(LIST_DEPTH)) begin
        status_next = olpe_pkg::ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end else if (is_del) begin
      if (count == '0) begin
        status_next = olpe_pkg::ST_EMPTY;
      end else if (pos_ext >= cnt_ext) begin
        status_next = olpe_pkg::ST_BADPOS;
      end else begin
        do_del = 1'b1;
      end
    end else if (is_loc) begin
      if (count == '0) begin
        status_next = olpe_pkg::ST_EMPTY;
      end
    end
  end

  // cell row: each cell looks at its neighbors and its own compare
  always_comb begin
    pick = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      pick = pick | (cells[i] & {olpe_pkg::PLATE_W{PW'(i) == pos_ext}});
      match_next[i] = is_loc && (cells[i] == plate_q) && (CW'(i) < count);
      cells_next[i] = cells[i];
      if (do_ins) begin
        if (PW'(i) == ins_at) begin
          cells_next[i] = plate_q;
        end else if ((i > 0) && (PW'(i) > ins_at)) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if ((i < LIST_DEPTH - 1) && (PW'(i) >= pos_ext)) begin
          cells_next[i] = cells[(i < LIST_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
    removed_next = do_del ? pick : '0;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        cells[i] <= cells_next[i];
      end
      status_q  <= status_next;
      removed_q <= removed_next;
      locate_q  <= is_loc;
      match_q   <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // last match wins
  always_comb begin
    last_idx = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (match_q[i]) begin
        last_idx = IW'(i);
      end
    end
    found      = |match_q;
    after_full = found ? (count - CW'(last_idx) - CW'(1)) : count;
  end

  assign status        = status_q;
  assign removed_plate = removed_q;
  assign before_count  = olpe_pkg::BEFORE_W'(last_idx);
  assign after_count   = locate_q ? olpe_pkg::AFTER_W'(after_full) : '0;
  assign list_length   = olpe_pkg::LEN_W'(count);

endmodule
`default_nettype wire

[rtl/ordered_list_position_engine_top.sv]
`default_nettype none
// Ordered list of up to LIST_DEPTH plate numbers, head at entry 0. Pulse start
// with a request while busy is low; busy rises for one cycle, then the result
// appears for exactly one cycle with done high. The receiver cannot stall, so
// it must take every result in that cycle. A new item may be started in the
// cycle that done is high: the execute state shifts and compares the whole
// cell row in parallel and registers the match flags, and in the report
// state the last match is encoded into before/after counts. list_length is
// the count after the request; status reports empty, bad position or full.
module ordered_list_position_engine_top #(
  parameter int LIST_DEPTH = 64
) (
  input  wire  logic                              clk,
  input  wire  logic                              rst,
  input  wire  logic                              start,
  output       logic                              busy,
  input  wire  logic [olpe_pkg::REQ_W-1:0]        req_type,
  input  wire  logic [olpe_pkg::POS_W-1:0]        position,
  input  wire  logic [olpe_pkg::PLATE_W-1:0]      plate,
  output       logic                              done,
  output       logic [olpe_pkg::STATUS_W-1:0]     status,
  output       logic [olpe_pkg::PLATE_W-1:0]      removed_plate,
  output       logic                              found,
  output       logic [olpe_pkg::BEFORE_W-1:0]     before_count,
  output       logic [olpe_pkg::AFTER_W-1:0]      after_count,
  output       logic [olpe_pkg::LEN_W-1:0]        list_length
);

  olpe_pkg::cmd_t cmd;

  olpe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  olpe_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .position      (position),
    .plate         (plate),
    .status        (status),
    .removed_plate (removed_plate),
    .found         (found),
    .before_count  (before_count),
    .after_count   (after_count),
    .list_length   (list_length)
  );

  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not enter execute");

  a_exec_report : assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execute not followed by one result");

  a_found_ok : assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == olpe_pkg::ST_OK && removed_plate == '0))
    else $error("locate hit with bad status or removed plate");

  a_len_stable : assert property (@(posedge clk) disable iff (rst)
    (done && status != olpe_pkg::ST_OK) |-> (list_length == $past(list_length, 2)))
    else $error("failed request changed the list length");

endmodule
`default_nettype wire
